FILE: rtl/core/mcsr_pkg.sv
package mcsr_pkg;

    // One host request: select event or host byte
    typedef struct packed {
        logic       operation;
        logic [7:0] host_byte;
    } req_t;

    // One card reply
    typedef struct packed {
        logic [7:0] reply_byte;
        logic       transfer_end;
    } rsp_t;

    // Operation codes on the request channel
    localparam logic OP_SELECT = 1'b0;

    // Command bytes
    localparam logic [7:0] CMD_READ   = 8'h52;
    localparam logic [7:0] CMD_WRITE  = 8'h57;
    localparam logic [7:0] CMD_GET_ID = 8'h53;

    // Fixed reply bytes
    localparam logic [7:0] RPL_ID1     = 8'h5a;
    localparam logic [7:0] RPL_ID2     = 8'h5d;
    localparam logic [7:0] RPL_ACK1    = 8'h5c;
    localparam logic [7:0] RPL_ACK2    = 8'h5d;
    localparam logic [7:0] RPL_GOOD    = 8'h47;
    localparam logic [7:0] RPL_BAD     = 8'h4e;
    localparam logic [7:0] RPL_INVALID = 8'hff;
    localparam logic [7:0] RPL_ZERO    = 8'h00;

    // Status flag: reset value and write-failure bit
    localparam logic [7:0] STAT_INIT    = 8'h08;
    localparam logic [7:0] STAT_WR_FAIL = 8'h04;

    // Erased memory contents
    localparam logic [7:0] ERASED_BYTE = 8'hff;

    // Cycles from a new sector number to a settled base offset
    localparam logic [1:0] BASE_LAT = 2'd3;

    // Get-ID reply sequence
    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h5a;
            3'd1:    b = 8'h5d;
            3'd2:    b = 8'h5c;
            3'd3:    b = 8'h5d;
            3'd4:    b = 8'h04;
            3'd7:    b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/mcsr_card_ram.sv
module mcsr_card_ram #(
    parameter int DEPTH = 131072,
    parameter int AW    = 17
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/mcsr_sector_base.sv
module mcsr_sector_base #(
    parameter int SECTOR_BYTES = 128,
    parameter int CARD_BYTES   = 131072,
    parameter int SN_W         = 10,
    parameter int AW           = 17
) (
    input  logic            aclk,
    input  logic [SN_W-1:0] sector,
    output logic [AW-1:0]   base
);

    // x = sector * SECTOR_BYTES, base = x mod CARD_BYTES
    localparam int XW    = SN_W + $clog2(SECTOR_BYTES);
    localparam int RW    = ((XW > AW) ? XW : AW) + 1;
    localparam int M_VAL = (1 << XW) / CARD_BYTES;

    localparam logic [XW-1:0] SB_C   = XW'(SECTOR_BYTES);
    localparam logic [XW-1:0] RECIP  = XW'(M_VAL);
    localparam logic [RW-1:0] CARD_C = RW'(CARD_BYTES);

    logic [XW-1:0]   x_reg;
    logic [XW-1:0]   x2_reg;
    logic [XW-1:0]   q_reg;
    logic [AW-1:0]   base_reg;
    logic [2*XW-1:0] q_prod;
    logic [RW-1:0]   rem;

    // Quotient estimate by reciprocal; it may fall one short
    assign q_prod = {{XW{1'b0}}, x_reg} * {{XW{1'b0}}, RECIP};

    // Remainder with a single correction step
    always_comb begin
        rem = RW'(x2_reg) - RW'(q_reg) * CARD_C;
        if (rem >= CARD_C) begin
            rem = rem - CARD_C;
        end
    end

    // Three-stage pipeline, runs every cycle
    always_ff @(posedge aclk) begin
        x_reg    <= sector * SB_C;
        x2_reg   <= x_reg;
        q_reg    <= q_prod[2*XW-1:XW];
        base_reg <= rem[AW-1:0];
    end

    assign base = base_reg;

endmodule

FILE: rtl/core/memory_card_serial_responder.sv
// Card-side responder for a byte-serial memory card exchange.
// Requests enter on s_valid/s_ready/s_data: operation 0 is a select event
// that restarts command parsing and gives no reply; operation 1 carries one
// host byte, which gives at most one reply on m_valid/m_ready/m_data.
// Each accepted byte is handled in a single pass; its reply sits in the
// output register in the cycle after acceptance, so the block takes one
// request per cycle while s_ready is high. After the address LSB of a read
// or write, s_ready drops while the sector base offset passes through the
// three-stage multiply and modulo pipeline; sector data is then read from a
// prefetch of the card RAM issued at the previous edge and written straight
// in. After reset the card RAM is filled with 0xFF, one byte per cycle,
// across all CARD_BYTES addresses (131072 by default) with s_ready low.
// When the receiver stalls, the reply is held in the output register and
// s_ready follows m_ready, so nothing is lost or repeated.
module memory_card_serial_responder #(
    parameter int SECTOR_BYTES      = 128,
    parameter int CARD_BYTES        = 131072,
    parameter int SECTOR_INDEX_MASK = 1023
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mcsr_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mcsr_pkg::rsp_t m_data
);

    import mcsr_pkg::*;

    localparam int AW   = $clog2(CARD_BYTES);
    localparam int SN_W = $clog2(SECTOR_INDEX_MASK + 1);

    localparam logic [AW:0]     CARD_C    = (AW+1)'(CARD_BYTES);
    localparam logic [AW-1:0]   CLEAR_END = AW'(CARD_BYTES - 1);
    localparam logic [7:0]      IDX_LAST  = 8'(SECTOR_BYTES - 1);
    localparam logic [15:0]     SN_MASK   = 16'(SECTOR_INDEX_MASK);

    typedef enum logic [4:0] {
        PH_IDLE, PH_CMD, PH_INVALID,
        PH_RD_ID1, PH_RD_ID2, PH_RD_MSB, PH_RD_LSB, PH_RD_ACK1, PH_RD_ACK2,
        PH_RD_CMSB, PH_RD_CLSB, PH_RD_DATA, PH_RD_CSUM, PH_RD_END,
        PH_WR_ID1, PH_WR_ID2, PH_WR_MSB, PH_WR_LSB, PH_WR_DATA, PH_WR_CSUM,
        PH_WR_ACK1, PH_WR_ACK2, PH_WR_END, PH_GET_ID
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      status_reg, status_next;
    logic [SN_W-1:0] sector_reg, sector_next;
    logic [7:0]      addr_hi_reg, addr_hi_next;
    logic [7:0]      addr_lo_reg, addr_lo_next;
    logic [7:0]      csum_reg, csum_next;
    logic [7:0]      idx_reg, idx_next;
    logic            wgood_reg, wgood_next;
    logic [1:0]      busy_reg, busy_next;
    logic            clear_reg, clear_next;
    logic [AW-1:0]   clear_addr_reg, clear_addr_next;
    logic            m_valid_reg, m_valid_next;
    rsp_t            m_data_reg, m_data_next;

    logic            accept;
    logic            produce;
    logic            data_we;
    rsp_t            rsp;
    logic [AW-1:0]   base;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    // Byte address within the card: base offset plus index, wrapped once
    function automatic logic [AW-1:0] card_addr(input logic [AW-1:0] b,
                                                input logic [7:0] i);
        logic [AW:0] sum;
        sum = {1'b0, b} + (AW+1)'(i);
        if (sum >= CARD_C) begin
            sum = sum - CARD_C;
        end
        return sum[AW-1:0];
    endfunction

    assign s_ready = !clear_reg && (busy_reg == 2'd0) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Protocol decode for one request
    always_comb begin
        phase_next   = phase_reg;
        status_next  = status_reg;
        sector_next  = sector_reg;
        addr_hi_next = addr_hi_reg;
        addr_lo_next = addr_lo_reg;
        csum_next    = csum_reg;
        idx_next     = idx_reg;
        wgood_next   = wgood_reg;
        busy_next    = (busy_reg != 2'd0) ? busy_reg - 2'd1 : 2'd0;
        produce      = 1'b0;
        data_we      = 1'b0;
        rsp          = '0;

        if (accept) begin
            if (s_data.operation == OP_SELECT) begin
                phase_next = PH_CMD;
            end else begin
                produce = 1'b1;
                case (phase_reg)
                    PH_CMD: begin
                        rsp.reply_byte = status_reg;
                        if (s_data.host_byte == CMD_READ) begin
                            phase_next = PH_RD_ID1;
                            csum_next  = 8'h00;
                            idx_next   = 8'h00;
                        end else if (s_data.host_byte == CMD_WRITE) begin
                            phase_next = PH_WR_ID1;
                            csum_next  = 8'h00;
                            idx_next   = 8'h00;
                            wgood_next = 1'b1;
                        end else if (s_data.host_byte == CMD_GET_ID) begin
                            phase_next = PH_GET_ID;
                            idx_next   = 8'h00;
                        end else begin
                            phase_next = PH_INVALID;
                        end
                    end
                    PH_INVALID: begin
                        rsp.reply_byte   = RPL_INVALID;
                        rsp.transfer_end = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                    PH_RD_ID1: begin
                        rsp.reply_byte = RPL_ID1;
                        phase_next     = PH_RD_ID2;
                    end
                    PH_RD_ID2: begin
                        rsp.reply_byte = RPL_ID2;
                        phase_next     = PH_RD_MSB;
                    end
                    PH_RD_MSB, PH_WR_MSB: begin
                        addr_hi_next   = s_data.host_byte;
                        rsp.reply_byte = RPL_ZERO;
                        phase_next     = (phase_reg == PH_RD_MSB) ? PH_RD_LSB : PH_WR_LSB;
                    end
                    PH_RD_LSB, PH_WR_LSB: begin
                        addr_lo_next   = s_data.host_byte;
                        sector_next    = SN_W'({addr_hi_reg, s_data.host_byte} & SN_MASK);
                        csum_next      = addr_hi_reg ^ s_data.host_byte;
                        idx_next       = 8'h00;
                        busy_next      = BASE_LAT;
                        rsp.reply_byte = addr_hi_reg;
                        phase_next     = (phase_reg == PH_RD_LSB) ? PH_RD_ACK1 : PH_WR_DATA;
                    end
                    PH_RD_ACK1: begin
                        rsp.reply_byte = RPL_ACK1;
                        phase_next     = PH_RD_ACK2;
                    end
                    PH_RD_ACK2: begin
                        rsp.reply_byte = RPL_ACK2;
                        phase_next     = PH_RD_CMSB;
                    end
                    PH_RD_CMSB: begin
                        rsp.reply_byte = addr_hi_reg;
                        phase_next     = PH_RD_CLSB;
                    end
                    PH_RD_CLSB: begin
                        rsp.reply_byte = addr_lo_reg;
                        idx_next       = 8'h00;
                        phase_next     = PH_RD_DATA;
                    end
                    PH_RD_DATA: begin
                        // prefetched byte at the current address
                        rsp.reply_byte = ram_rdata;
                        csum_next      = csum_reg ^ ram_rdata;
                        if (idx_reg >= IDX_LAST) begin
                            idx_next   = 8'h00;
                            phase_next = PH_RD_CSUM;
                        end else begin
                            idx_next = idx_reg + 8'd1;
                        end
                    end
                    PH_RD_CSUM: begin
                        rsp.reply_byte = csum_reg;
                        phase_next     = PH_RD_END;
                    end
                    PH_RD_END: begin
                        rsp.reply_byte   = RPL_GOOD;
                        rsp.transfer_end = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                    PH_WR_ID1: begin
                        rsp.reply_byte = RPL_ID1;
                        phase_next     = PH_WR_ID2;
                    end
                    PH_WR_ID2: begin
                        rsp.reply_byte = RPL_ID2;
                        phase_next     = PH_WR_MSB;
                    end
                    PH_WR_DATA: begin
                        data_we        = 1'b1;
                        rsp.reply_byte = s_data.host_byte;
                        csum_next      = csum_reg ^ s_data.host_byte;
                        if (idx_reg >= IDX_LAST) begin
                            idx_next   = 8'h00;
                            phase_next = PH_WR_CSUM;
                        end else begin
                            idx_next = idx_reg + 8'd1;
                        end
                    end
                    PH_WR_CSUM: begin
                        wgood_next     = (s_data.host_byte == csum_reg);
                        rsp.reply_byte = s_data.host_byte;
                        phase_next     = PH_WR_ACK1;
                    end
                    PH_WR_ACK1: begin
                        rsp.reply_byte = RPL_ACK1;
                        phase_next     = PH_WR_ACK2;
                    end
                    PH_WR_ACK2: begin
                        rsp.reply_byte = RPL_ACK2;
                        phase_next     = PH_WR_END;
                    end
                    PH_WR_END: begin
                        status_next      = (status_reg & ~STAT_WR_FAIL) |
                                           (wgood_reg ? 8'h00 : STAT_WR_FAIL);
                        rsp.reply_byte   = wgood_reg ? RPL_GOOD : RPL_BAD;
                        rsp.transfer_end = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                    PH_GET_ID: begin
                        rsp.reply_byte = id_byte(idx_reg[2:0]);
                        if (idx_reg[2:0] == 3'd7) begin
                            rsp.transfer_end = 1'b1;
                            phase_next       = PH_IDLE;
                            idx_next         = 8'h00;
                        end else begin
                            idx_next = {5'd0, idx_reg[2:0] + 3'd1};
                        end
                    end
                    default: begin
                        // idle or unused code: no reply
                        produce    = 1'b0;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Erase sweep after reset
    always_comb begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg) begin
            clear_addr_next = clear_addr_reg + AW'(1);
            if (clear_addr_reg == CLEAR_END) begin
                clear_next = 1'b0;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (produce) begin
            m_valid_next = 1'b1;
            m_data_next  = rsp;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // RAM ports: write from sweep or data byte, read ahead at the next index
    assign ram_we    = clear_reg || data_we;
    assign ram_waddr = clear_reg ? clear_addr_reg : card_addr(base, idx_reg);
    assign ram_wdata = clear_reg ? ERASED_BYTE : s_data.host_byte;
    assign ram_raddr = card_addr(base, idx_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            status_reg     <= STAT_INIT;
            sector_reg     <= '0;
            addr_hi_reg    <= 8'h00;
            addr_lo_reg    <= 8'h00;
            csum_reg       <= 8'h00;
            idx_reg        <= 8'h00;
            wgood_reg      <= 1'b1;
            busy_reg       <= 2'd0;
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end else begin
            phase_reg      <= phase_next;
            status_reg     <= status_next;
            sector_reg     <= sector_next;
            addr_hi_reg    <= addr_hi_next;
            addr_lo_reg    <= addr_lo_next;
            csum_reg       <= csum_next;
            idx_reg        <= idx_next;
            wgood_reg      <= wgood_next;
            busy_reg       <= busy_next;
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
        end
    end

    mcsr_sector_base #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .CARD_BYTES   (CARD_BYTES),
        .SN_W         (SN_W),
        .AW           (AW)
    ) u_base (
        .aclk   (aclk),
        .sector (sector_reg),
        .base   (base)
    );

    mcsr_card_ram #(
        .DEPTH (CARD_BYTES),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
